FILE: hdl/tss_pkg.sv
`default_nettype none
package tss_pkg;

    localparam int MAX_ROWS   = 64;
    localparam int ROW_W      = 6;
    localparam int CNT_W      = 7;
    localparam int FRAC_W     = 24;
    localparam int DIV_W      = 56;
    localparam int DIV_CNT_W  = 6;

    localparam logic signed [31:0] RESET_MAIN  = 32'sh0200_0000;
    localparam logic signed [31:0] RESET_LOWER = -32'sh0100_0000;
    localparam logic signed [31:0] RESET_UPPER = -32'sh0100_0000;

    localparam logic [1:0] REG_MAIN  = 2'd0;
    localparam logic [1:0] REG_LOWER = 2'd1;
    localparam logic [1:0] REG_UPPER = 2'd2;

    typedef struct packed {
        logic signed [31:0] rhs_value;
        logic               last_item;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] solution_value;
        logic [5:0]         solution_index;
        logic               last_result;
        logic               singular_flag;
    } t_out_word;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ROW0_DIV,
        ST_RATIO_DIV,
        ST_RATIO_WAIT,
        ST_PIVOT_MUL,
        ST_PIVOT_SUB,
        ST_YPREV_RD,
        ST_Y_MUL,
        ST_Y_SUB,
        ST_Y_DIV,
        ST_Y_WAIT,
        ST_ROW_WR,
        ST_BS_RD,
        ST_BS_MUL,
        ST_BS_SUB,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_HOLD,
        ST_CLEAR
    } t_state;

    // datapath commands
    typedef struct packed {
        logic       load_in;      // latch rhs word and last flag
        logic       pivot_main;   // pivot <= b
        logic       div_start;
        logic       div_ratio;    // 1: c/pivot, 0: acc/pivot (or f/b on row 0)
        logic       div_rhs;      // numerator is latched rhs
        logic       ratio_save;   // ratio reg <= quotient
        logic       mul_ratio;    // mul a*ratio
        logic       mul_ya;       // mul a*y_prev
        logic       mul_bs;       // mul ratio[i+1]*y[i+1]
        logic       pivot_sub;    // pivot <= sat(b - prod)
        logic       acc_sub;      // acc  <= sat(f - prod)
        logic       y_save;       // y reg <= quotient
        logic       wr_row;       // write stores at row
        logic       rd_prev;      // read y store at row-1
        logic       rd_bs;        // read stores at idx+1 and y at idx
        logic       bs_write;     // y[idx] <= sat(y[idx] - prod)
        logic       rd_out;       // read y at idx
        logic       out_load;
        logic       row_inc;
        logic       clr_run;
        logic [5:0] idx;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic [6:0] row_count;
        logic       last;
    } t_status;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)       return 32'sh7fff_ffff;
        else if (v < -66'sd2147483648) return 32'sh8000_0000;
        else                           return v[31:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/tss_divider.sv
`default_nettype none
module tss_divider (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic                    o_zero,
    output logic signed [31:0]      o_quot
);
    import tss_pkg::*;

    logic [DIV_W-1:0]      r_rem, n_rem;
    logic [DIV_W-1:0]      r_q, n_q;
    logic [31:0]           r_den;
    logic                  r_neg, r_busy, r_done, r_zero;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DIV_W:0]        w_trial;
    logic [DIV_W-1:0]      w_shift;
    logic [DIV_W:0]        w_mag;
    logic signed [65:0]    w_sq;
    logic [DIV_W-1:0]      w_num_abs;

    // magnitude of num * 2^24 (fits 56 bits)
    assign w_num_abs = i_num[31] ? {DIV_W{1'b0}} - {i_num, {FRAC_W{1'b0}}}
                                 : {i_num, {FRAC_W{1'b0}}};

    // restoring division, one quotient bit per cycle
    always_comb begin
        w_shift = {r_rem[DIV_W-2:0], r_q[DIV_W-1]};
        w_trial = {1'b0, w_shift} - {{(DIV_W-32+1){1'b0}}, r_den};
        if (!w_trial[DIV_W]) begin
            n_rem = w_trial[DIV_W-1:0];
            n_q   = {r_q[DIV_W-2:0], 1'b1};
        end else begin
            n_rem = w_shift;
            n_q   = {r_q[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= (i_den != 32'sd0);
                r_done <= (i_den == 32'sd0);
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_q    <= w_num_abs;
            r_den  <= i_den[31] ? 32'd0 - i_den : i_den;
            r_neg  <= i_num[31] ^ i_den[31];
            r_zero <= (i_den == 32'sd0);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign w_mag  = {1'b0, r_q};
    assign w_sq   = r_neg ? -$signed({9'd0, w_mag}) : $signed({9'd0, w_mag});
    assign o_done = r_done;
    assign o_zero = r_zero;
    assign o_quot = r_zero ? 32'sd0 : sat32(w_sq);

endmodule
`default_nettype wire

FILE: hdl/tss_datapath.sv
`default_nettype none
module tss_datapath (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire tss_pkg::t_cmd      i_cmd,
    input  wire tss_pkg::t_in_word  i_in_word,
    input  wire logic signed [31:0] i_main,
    input  wire logic signed [31:0] i_lower,
    input  wire logic signed [31:0] i_upper,
    output tss_pkg::t_status        o_status,
    output tss_pkg::t_out_word      o_out_word
);
    import tss_pkg::*;

    logic signed [31:0] ratio_mem [MAX_ROWS];
    logic signed [31:0] y_mem     [MAX_ROWS];

    logic signed [31:0] r_rhs, r_pivot, r_ratio, r_y, r_acc;
    logic signed [63-FRAC_W:0] r_prod;
    logic signed [31:0] r_rd_ratio, r_rd_y1, r_rd_y0;
    logic signed [63:0] r_mul;
    logic               r_last, r_sing;
    logic [CNT_W-1:0]   r_row;
    logic signed [31:0] w_div_num, w_div_den, w_quot;
    logic               w_div_done, w_div_zero;
    logic signed [31:0] w_ma, w_mb;
    logic [ROW_W-1:0]   w_idx1, w_prev;
    logic [ROW_W-1:0]   w_row6;
    t_out_word          r_out;

    assign w_row6 = r_row[ROW_W-1:0];
    assign w_idx1 = i_cmd.idx + 1'b1;
    assign w_prev = w_row6 - 1'b1;

    // divider operand select
    assign w_div_num = i_cmd.div_ratio ? i_upper : (i_cmd.div_rhs ? r_rhs : r_acc);
    assign w_div_den = r_pivot;

    tss_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_zero  (w_div_zero),
        .o_quot  (w_quot)
    );

    // multiplier operand select
    always_comb begin
        w_ma = i_lower;
        w_mb = r_ratio;
        if (i_cmd.mul_ya) begin
            w_mb = r_rd_y0;
        end else if (i_cmd.mul_bs) begin
            w_ma = r_rd_ratio;
            w_mb = r_rd_y1;
        end
    end

    // control-side registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_sing <= 1'b0;
            r_last <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_last <= i_in_word.last_item || (r_row >= CNT_W'(MAX_ROWS - 1));
            end
            if (w_div_done && w_div_zero) r_sing <= 1'b1;
            if (i_cmd.row_inc) r_row <= r_row + 1'b1;
            if (i_cmd.clr_run) begin
                r_row  <= '0;
                r_sing <= 1'b0;
            end
        end
    end

    // arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in)    r_rhs <= i_in_word.rhs_value;
        if (i_cmd.pivot_main) r_pivot <= i_main;
        if (i_cmd.mul_ratio || i_cmd.mul_ya || i_cmd.mul_bs) r_mul <= w_ma * w_mb;
        if (i_cmd.ratio_save) r_ratio <= w_quot;
        if (i_cmd.y_save)     r_y <= w_quot;
        // floor shift by 24, full width; only the difference saturates
        r_prod <= r_mul[63:FRAC_W];
        if (i_cmd.pivot_sub)
            r_pivot <= sat32(66'(i_main) - 66'(r_prod));
        if (i_cmd.acc_sub)
            r_acc <= sat32(66'(r_rhs) - 66'(r_prod));
        if (i_cmd.bs_write)
            r_acc <= sat32(66'(r_rd_y0) - 66'(r_prod));
    end

    // stores: one write port, registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_row) begin
            y_mem[w_row6] <= r_y;
            ratio_mem[w_row6] <= r_ratio;
        end else if (i_cmd.bs_write) begin
            y_mem[i_cmd.idx] <= sat32(66'(r_rd_y0) - 66'(r_prod));
        end
        if (i_cmd.rd_prev) r_rd_y0 <= y_mem[w_prev];
        if (i_cmd.rd_bs) begin
            r_rd_ratio <= ratio_mem[w_idx1];
            r_rd_y1    <= y_mem[w_idx1];
            r_rd_y0    <= y_mem[i_cmd.idx];
        end
        if (i_cmd.rd_out) r_rd_y0 <= y_mem[i_cmd.idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.solution_value <= r_rd_y0;
            r_out.solution_index <= i_cmd.idx;
            r_out.last_result    <= (i_cmd.idx == w_row6 - 1'b1);
            r_out.singular_flag  <= r_sing;
        end
    end

    assign o_out_word         = r_out;
    assign o_status.div_done  = w_div_done;
    assign o_status.row_count = r_row;
    assign o_status.last      = r_last;

endmodule
`default_nettype wire

FILE: hdl/tss_control.sv
`default_nettype none
module tss_control (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire tss_pkg::t_status i_status,
    output tss_pkg::t_cmd        o_cmd
);
    import tss_pkg::*;

    t_state           r_state, n_state;
    logic [ROW_W-1:0] r_idx, n_idx;
    logic             r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        o_in_ready  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    if (i_status.row_count == '0) begin
                        o_cmd.pivot_main = 1'b1;
                        n_state = ST_ROW0_DIV;
                    end else begin
                        n_state = ST_RATIO_DIV;
                    end
                end
            end
            ST_ROW0_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_rhs   = 1'b1;
                n_state = ST_Y_WAIT;
            end
            ST_RATIO_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_ratio = 1'b1;
                n_state = ST_RATIO_WAIT;
            end
            ST_RATIO_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.ratio_save = 1'b1;
                    n_state = ST_PIVOT_MUL;
                end
            end
            ST_PIVOT_MUL: begin
                o_cmd.mul_ratio = 1'b1;
                o_cmd.rd_prev   = 1'b1;
                n_state = ST_PIVOT_SUB;
            end
            ST_PIVOT_SUB: begin
                o_cmd.mul_ya    = 1'b1;
                n_state = ST_YPREV_RD;
            end
            ST_YPREV_RD: begin
                // r_prod holds a*ratio now
                o_cmd.pivot_sub = 1'b1;
                n_state = ST_Y_SUB;
            end
            ST_Y_MUL: begin
                n_state = ST_Y_SUB;
            end
            ST_Y_SUB: begin
                o_cmd.acc_sub = 1'b1;
                n_state = ST_Y_DIV;
            end
            ST_Y_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_Y_WAIT;
            end
            ST_Y_WAIT: begin
                if (i_status.div_done) begin
                    o_cmd.y_save = 1'b1;
                    n_state = ST_ROW_WR;
                end
            end
            ST_ROW_WR: begin
                o_cmd.wr_row  = 1'b1;
                o_cmd.row_inc = 1'b1;
                if (i_status.last) begin
                    if (i_status.row_count == '0) begin
                        n_idx   = '0;
                        n_state = ST_OUT_RD;
                    end else begin
                        n_idx   = i_status.row_count[ROW_W-1:0] - 1'b1;
                        n_state = ST_BS_RD;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_BS_RD: begin
                o_cmd.rd_bs = 1'b1;
                n_state = ST_BS_MUL;
            end
            ST_BS_MUL: begin
                o_cmd.mul_bs = 1'b1;
                n_state = ST_BS_SUB;
            end
            ST_BS_SUB: begin
                if (i_status.div_done == 1'b0) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                o_cmd.bs_write = 1'b1;
                if (r_idx == '0) begin
                    n_state = ST_OUT_RD;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = ST_BS_RD;
                end
            end
            ST_OUT_RD: begin
                o_cmd.rd_out = 1'b1;
                n_state = ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                o_cmd.out_load = 1'b1;
                n_out_valid    = 1'b1;
                n_state = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_idx == i_status.row_count[ROW_W-1:0] - 1'b1) begin
                        o_cmd.clr_run = 1'b1;
                        n_idx   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = ST_OUT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE)) else $error("ready outside idle");
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_state == ST_OUT_HOLD)) else $error("valid outside hold");
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid)) else $error("input taken while output pending");

endmodule
`default_nettype wire

FILE: hdl/tridiagonal_system_solver_core.sv
`default_nettype none
// Tridiagonal solver, Thomas algorithm, signed Q8.24.
// Input channel: one right-hand-side word per handshake; last_item ends a run
// (a run also ends on its 64th word). Nothing is emitted until a run ends.
// Each word runs two 56-step restoring divisions by the running pivot plus 8
// control steps before the core is ready again; row 0 needs one division.
// At run end back substitution steps through BS_RD, BS_MUL, BS_SUB and
// CLEAR for each row, then the solution words leave in ascending row order,
// each read, loaded and held in turn; o_valid holds with a stable word while
// the receiver stalls.
// No new input word is taken until the run's last solution word is accepted.
// Coefficients b, a, c are written through the APB port at 0x0, 0x4, 0x8,
// by the user only while idle (the core does not enforce it). Reset sets
// 2.0, -1.0, -1.0 and clears the row count and the singular flag. Row stores
// are undefined after reset; every entry is written before it is read in a run.
module tridiagonal_system_solver_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire tss_pkg::t_in_word  i_data,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output tss_pkg::t_out_word      o_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [3:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);
    import tss_pkg::*;

    logic signed [31:0] r_main, r_lower, r_upper;
    t_cmd               w_cmd;
    t_status            w_status;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main  <= RESET_MAIN;
            r_lower <= RESET_LOWER;
            r_upper <= RESET_UPPER;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_MAIN:  r_main  <= pwdata;
                REG_LOWER: r_lower <= pwdata;
                REG_UPPER: r_upper <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_MAIN:  prdata = r_main;
            REG_LOWER: prdata = r_lower;
            REG_UPPER: prdata = r_upper;
            default:   prdata = 32'd0;
        endcase
    end

    assign pready = 1'b1;

    tss_control u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    tss_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_in_word  (i_data),
        .i_main     (r_main),
        .i_lower    (r_lower),
        .i_upper    (r_upper),
        .o_status   (w_status),
        .o_out_word (o_data)
    );

endmodule
`default_nettype wire

FILE: tb/tridiagonal_system_solver_core_tb.sv
`default_nettype none

// Expected solution words of one block, checked in order
class solution_scoreboard;
    // coefficients and elimination state
    logic signed [31:0] coef_main;
    logic signed [31:0] coef_lower;
    logic signed [31:0] coef_upper;
    logic signed [63:0] ratio_row [64];
    logic signed [63:0] y_row [64];
    logic signed [63:0] pivot;
    int unsigned        rows;
    bit                 singular;
    tss_pkg::t_out_word pending_q[$];
    int                 mismatches;

    function new();
        coef_main  = tss_pkg::RESET_MAIN;
        coef_lower = tss_pkg::RESET_LOWER;
        coef_upper = tss_pkg::RESET_UPPER;
        pivot      = 0;
        rows       = 0;
        singular   = 0;
        mismatches = 0;
    endfunction

    function logic signed [63:0] clamp(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // Q8.24 product, floor rounding
    function logic signed [63:0] fx_mul(input logic signed [63:0] x,
                                        input logic signed [63:0] y);
        logic signed [63:0] p;
        p = x * y;
        return p >>> 24;
    endfunction

    // Q8.24 quotient, truncated; zero divisor marks the run singular
    function logic signed [63:0] fx_div(input logic signed [63:0] num,
                                        input logic signed [63:0] den);
        logic signed [63:0] n;
        if (den == 0) begin
            singular = 1;
            return 0;
        end
        n = num * 64'sd16777216;
        return clamp(n / den);
    endfunction

    function void set_coef(input logic [1:0] idx, input logic [31:0] v);
        case (idx)
            tss_pkg::REG_MAIN:  coef_main  = v;
            tss_pkg::REG_LOWER: coef_lower = v;
            tss_pkg::REG_UPPER: coef_upper = v;
            default: ;
        endcase
    endfunction

    // forward elimination for one accepted word; emits the solution at run end
    function void note_rhs(input tss_pkg::t_in_word w);
        int unsigned r;
        bit done;
        logic signed [63:0] f;
        tss_pkg::t_out_word o;
        r    = rows;
        f    = w.rhs_value;
        done = w.last_item || (r >= 63);
        if (r >= 64) r = 63;
        if (r == 0) begin
            pivot = coef_main;
            y_row[0] = fx_div(f, pivot);
        end else begin
            ratio_row[r] = fx_div(coef_upper, pivot);
            pivot = clamp(coef_main - fx_mul(coef_lower, ratio_row[r]));
            y_row[r] = fx_div(clamp(f - fx_mul(coef_lower, y_row[r-1])), pivot);
        end
        rows = r + 1;
        if (!done) return;
        for (int i = int'(r) - 1; i >= 0; i--)
            y_row[i] = clamp(y_row[i] - fx_mul(ratio_row[i+1], y_row[i+1]));
        for (int i = 0; i <= int'(r); i++) begin
            o.solution_value = y_row[i][31:0];
            o.solution_index = i[5:0];
            o.last_result    = (i == int'(r));
            o.singular_flag  = singular;
            pending_q.push_back(o);
        end
        rows = 0;
        pivot = 0;
        singular = 0;
    endfunction

    function void check_solution(input tss_pkg::t_out_word got);
        tss_pkg::t_out_word exp_w;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected solution word %h", got);
            return;
        end
        exp_w = pending_q.pop_front();
        if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10)
                $display({"solution mismatch: exp val %h idx %0d last %b sing %b,",
                          " got val %h idx %0d last %b sing %b"},
                         exp_w.solution_value, exp_w.solution_index, exp_w.last_result,
                         exp_w.singular_flag, got.solution_value, got.solution_index,
                         got.last_result, got.singular_flag);
        end
    endfunction
endclass

module tridiagonal_system_solver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tss_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    t_in_word    in_word;
    logic        out_valid;
    logic        out_ready;
    t_out_word   out_word;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    solution_scoreboard sb;
    int  cycles = 0;
    bit  quiet;      // no idling in the closing stretch

    tridiagonal_system_solver_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_word),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // sample handshakes at the rising edge
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (rst_n && in_valid && in_ready) sb.note_rhs(in_word);
        if (rst_n && out_valid && out_ready) sb.check_solution(out_word);
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stall bursts
    initial begin
        out_ready = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    task automatic write_coef(input logic [1:0] idx, input logic [31:0] v);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.set_coef(idx, v);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // send one rhs word, holding valid until accepted; valid stays up for
    // the next word, drain() drops it
    task automatic send_rhs(input logic [31:0] v, input logic last);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{rhs_value: v, last_item: last};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_rhs();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $signed($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
        endcase
    endfunction

    task automatic send_block(input int n);
        for (int i = 0; i < n; i++)
            send_rhs(rand_rhs(), i == n - 1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    task automatic set_coefs(input logic [31:0] b, input logic [31:0] a,
                             input logic [31:0] c);
        write_coef(REG_MAIN, b);
        write_coef(REG_LOWER, a);
        write_coef(REG_UPPER, c);
    endtask

    initial begin
        sb = new();
        quiet = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: defaults, single row, field extremes
        send_rhs(32'h0100_0000, 1'b1);
        send_rhs(32'h7fff_ffff, 1'b0);
        send_rhs(32'h8000_0000, 1'b0);
        send_rhs(32'h0000_0000, 1'b0);
        send_rhs(32'hffff_ffff, 1'b1);
        drain();

        // zero main diagonal: singular on row 0
        set_coefs(32'h0, 32'h0100_0000, 32'h0100_0000);
        send_block(3);
        drain();

        // pivot hits zero mid-run: b=1, a=1, c=1
        set_coefs(32'h0100_0000, 32'h0100_0000, 32'h0100_0000);
        send_block(4);
        drain();

        // coefficient extremes
        set_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
        send_block(5);
        drain();
        set_coefs(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_block(2);
        drain();

        // too many rows: run ends on its 64th word with no last flag
        set_coefs(32'h0400_0000, 32'hff00_0000, 32'hff00_0000);
        for (int i = 0; i < 64; i++) send_rhs(rand_rhs(), 1'b0);
        drain();

        // random phases with fresh coefficients
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 5) quiet = 1;
            case ($urandom_range(0, 2))
                0: set_coefs($urandom(), $urandom(), $urandom());
                default: set_coefs($urandom_range(32'h0100_0000, 32'h0600_0000),
                                   -$signed($urandom_range(0, 32'h0200_0000)),
                                   $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
            endcase
            for (int k = 0; k < 62; ) begin
                int n;
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                                : $urandom_range(1, 8);
                send_block(n);
                k += n;
            end
            drain();
        end

        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

`default_nettype wire
